>>> design/pstc_pkg.sv
// Shared constants, types and the sine table for the per-slot DDS tone source.
package pstc_pkg;

    // Default samples per chunk, number of slots and field widths
    localparam int CHUNK_DEF = 32;
    localparam int SLOTS     = 4;
    localparam int SLOT_SEL_W = $clog2(SLOTS);
    localparam int SLOT_W    = 8;
    localparam int PHASE_W   = 32;
    localparam int STEP_W    = 31;
    localparam int SAMPLE_W  = 8;
    localparam int ROM_AW    = 8;

    // Seeded start of one chunk: starting phase and per-sample step
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [STEP_W-1:0]  step;
    } t_seed;

    // One sample request toward the table lookup stage
    typedef struct packed {
        logic [ROM_AW-1:0] idx;
        logic              last;
    } t_tap;

    // 128 + round(100 * sin(2*pi*i/256))
    localparam logic [SAMPLE_W-1:0] WAVE_ROM [256] = '{
        8'd128, 8'd130, 8'd133, 8'd135, 8'd138, 8'd140, 8'd143, 8'd145,
        8'd148, 8'd150, 8'd152, 8'd155, 8'd157, 8'd159, 8'd162, 8'd164,
        8'd166, 8'd169, 8'd171, 8'd173, 8'd175, 8'd177, 8'd179, 8'd181,
        8'd184, 8'd186, 8'd188, 8'd190, 8'd191, 8'd193, 8'd195, 8'd197,
        8'd199, 8'd200, 8'd202, 8'd204, 8'd205, 8'd207, 8'd208, 8'd210,
        8'd211, 8'd212, 8'd214, 8'd215, 8'd216, 8'd217, 8'd218, 8'd219,
        8'd220, 8'd221, 8'd222, 8'd223, 8'd224, 8'd224, 8'd225, 8'd226,
        8'd226, 8'd227, 8'd227, 8'd227, 8'd228, 8'd228, 8'd228, 8'd228,
        8'd228, 8'd228, 8'd228, 8'd228, 8'd228, 8'd227, 8'd227, 8'd227,
        8'd226, 8'd226, 8'd225, 8'd224, 8'd224, 8'd223, 8'd222, 8'd221,
        8'd220, 8'd219, 8'd218, 8'd217, 8'd216, 8'd215, 8'd214, 8'd212,
        8'd211, 8'd210, 8'd208, 8'd207, 8'd205, 8'd204, 8'd202, 8'd200,
        8'd199, 8'd197, 8'd195, 8'd193, 8'd191, 8'd190, 8'd188, 8'd186,
        8'd184, 8'd181, 8'd179, 8'd177, 8'd175, 8'd173, 8'd171, 8'd169,
        8'd166, 8'd164, 8'd162, 8'd159, 8'd157, 8'd155, 8'd152, 8'd150,
        8'd148, 8'd145, 8'd143, 8'd140, 8'd138, 8'd135, 8'd133, 8'd130,
        8'd128, 8'd126, 8'd123, 8'd121, 8'd118, 8'd116, 8'd113, 8'd111,
        8'd108, 8'd106, 8'd104, 8'd101, 8'd99,  8'd97,  8'd94,  8'd92,
        8'd90,  8'd87,  8'd85,  8'd83,  8'd81,  8'd79,  8'd77,  8'd75,
        8'd72,  8'd70,  8'd68,  8'd66,  8'd65,  8'd63,  8'd61,  8'd59,
        8'd57,  8'd56,  8'd54,  8'd52,  8'd51,  8'd49,  8'd48,  8'd46,
        8'd45,  8'd44,  8'd42,  8'd41,  8'd40,  8'd39,  8'd38,  8'd37,
        8'd36,  8'd35,  8'd34,  8'd33,  8'd32,  8'd32,  8'd31,  8'd30,
        8'd30,  8'd29,  8'd29,  8'd29,  8'd28,  8'd28,  8'd28,  8'd28,
        8'd28,  8'd28,  8'd28,  8'd28,  8'd28,  8'd29,  8'd29,  8'd29,
        8'd30,  8'd30,  8'd31,  8'd32,  8'd32,  8'd33,  8'd34,  8'd35,
        8'd36,  8'd37,  8'd38,  8'd39,  8'd40,  8'd41,  8'd42,  8'd44,
        8'd45,  8'd46,  8'd48,  8'd49,  8'd51,  8'd52,  8'd54,  8'd56,
        8'd57,  8'd59,  8'd61,  8'd63,  8'd65,  8'd66,  8'd68,  8'd70,
        8'd72,  8'd75,  8'd77,  8'd79,  8'd81,  8'd83,  8'd85,  8'd87,
        8'd90,  8'd92,  8'd94,  8'd97,  8'd99,  8'd101, 8'd104, 8'd106,
        8'd108, 8'd111, 8'd113, 8'd116, 8'd118, 8'd121, 8'd123, 8'd126
    };

endpackage

>>> design/pstc_seed.sv
// Two-stage seed pipeline: step select and chunk offset, then the phase multiply.
module pstc_seed #(
    parameter int CHUNK = pstc_pkg::CHUNK_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [pstc_pkg::SLOT_W-1:0]    i_slot,
    input  logic [pstc_pkg::PHASE_W-1:0]   i_chunk,
    input  logic [pstc_pkg::STEP_W-1:0]    i_steps [pstc_pkg::SLOTS],
    output logic                           o_valid,
    input  logic                           i_ready,
    output pstc_pkg::t_seed                o_seed
);

    localparam logic [pstc_pkg::PHASE_W-1:0] CHUNK_LEN = pstc_pkg::PHASE_W'(CHUNK);

    logic                           r_v1;
    logic [pstc_pkg::PHASE_W-1:0]   r_base;
    logic [pstc_pkg::STEP_W-1:0]    r_step1;
    logic                           r_v2;
    pstc_pkg::t_seed                r_seed;
    logic                           s1_ready;
    logic                           s2_ready;

    assign s2_ready = !r_v2 || i_ready;
    assign s1_ready = !r_v1 || s2_ready;
    assign o_ready  = s1_ready;
    assign o_valid  = r_v2;
    assign o_seed   = r_seed;

    // Stage 1: pick the slot's step, scale the chunk index by the chunk length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s1_ready) begin
            r_v1 <= i_valid;
        end
        if (s1_ready && i_valid) begin
            r_base  <= i_chunk * CHUNK_LEN;
            r_step1 <= i_steps[i_slot[pstc_pkg::SLOT_SEL_W-1:0]];
        end
    end

    // Stage 2: starting phase = offset * step, modulo 2^32
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (s2_ready) begin
            r_v2 <= r_v1;
        end
        if (s2_ready && r_v1) begin
            r_seed.phase <= r_base * {1'b0, r_step1};
            r_seed.step  <= r_step1;
        end
    end

endmodule

>>> design/pstc_gen.sv
// Phase accumulator: walks one chunk, one sample request per beat.
module pstc_gen #(
    parameter int CHUNK = pstc_pkg::CHUNK_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pstc_pkg::t_seed   i_seed,
    output logic              o_valid,
    input  logic              i_ready,
    output pstc_pkg::t_tap    o_tap
);

    localparam int CNT_W = (CHUNK > 1) ? $clog2(CHUNK) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CHUNK - 1);

    logic                           r_busy;
    logic [pstc_pkg::PHASE_W-1:0]   r_phase;
    logic [pstc_pkg::STEP_W-1:0]    r_step;
    logic [CNT_W-1:0]               r_cnt;
    logic                           adv;
    logic                           last;
    logic                           free;

    assign last    = (r_cnt == CNT_LAST);
    assign adv     = r_busy && i_ready;
    assign free    = !r_busy || (adv && last);
    assign o_ready = free;
    assign o_valid = r_busy;
    assign o_tap.idx  = r_phase[pstc_pkg::PHASE_W-1 -: pstc_pkg::ROM_AW];
    assign o_tap.last = last;

    // Load a new seed when free, otherwise step the phase each beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (free) begin
            r_busy <= i_valid;
        end
        if (free && i_valid) begin
            r_phase <= i_seed.phase;
            r_step  <= i_seed.step;
            r_cnt   <= '0;
        end else if (adv && !last) begin
            r_phase <= r_phase + {1'b0, r_step};
            r_cnt   <= r_cnt + 1'b1;
        end
    end

endmodule

>>> design/pstc_out.sv
// Table lookup into the output register.
module pstc_out (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  pstc_pkg::t_tap                  i_tap,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [pstc_pkg::SAMPLE_W-1:0]   o_sample,
    output logic                            o_last
);

    logic                           r_valid;
    logic [pstc_pkg::SAMPLE_W-1:0]  r_sample;
    logic                           r_last;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_sample = r_sample;
    assign o_last   = r_last;

    // Hold the beat until taken, then load the next looked-up sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_sample <= pstc_pkg::WAVE_ROM[i_tap.idx];
            r_last   <= i_tap.last;
        end
    end

endmodule

>>> design/per_slot_dds_tone_chunk_core.sv
// Top level of the per-slot DDS tone source: step registers and the sample pipeline.
// The first sample of a chunk goes through four register stages after its input beat:
// seed stage 1, seed stage 2, the phase accumulator and the output register.
// Throughput: CHUNK output beats per input beat, one per cycle unless the output stalls,
// set by the phase accumulator; the next chunk's seed is computed while the current one streams.
// Reset (synchronous, active low) clears all valid flags and the four step registers.
module per_slot_dds_tone_chunk_core #(
    parameter int CHUNK = pstc_pkg::CHUNK_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [pstc_pkg::SLOT_SEL_W-1:0] i_cfg_idx,
    input  logic [pstc_pkg::STEP_W-1:0]    i_cfg_data,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [39:0]                    s_axis_tdata,  // [7:0] slot_number, [39:8] chunk_index
    // output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,  // [7:0] sample
    output logic                           m_axis_tlast
);

    logic [pstc_pkg::STEP_W-1:0] r_steps [pstc_pkg::SLOTS];
    logic                        seed_valid;
    logic                        seed_ready;
    pstc_pkg::t_seed             seed;
    logic                        tap_valid;
    logic                        tap_ready;
    pstc_pkg::t_tap              tap;

    // Write the addressed step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pstc_pkg::SLOTS; i++) begin
                r_steps[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_steps[i_cfg_idx] <= i_cfg_data;
        end
    end

    pstc_seed #(.CHUNK(CHUNK)) u_seed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_slot  (s_axis_tdata[7:0]),
        .i_chunk (s_axis_tdata[39:8]),
        .i_steps (r_steps),
        .o_valid (seed_valid),
        .i_ready (seed_ready),
        .o_seed  (seed)
    );

    pstc_gen #(.CHUNK(CHUNK)) u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (seed_valid),
        .o_ready (seed_ready),
        .i_seed  (seed),
        .o_valid (tap_valid),
        .i_ready (tap_ready),
        .o_tap   (tap)
    );

    pstc_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (tap_valid),
        .o_ready  (tap_ready),
        .i_tap    (tap),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_sample (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );

endmodule
